>>> hdl/wps_pkg.sv
// ----------------------------------------------------------------------------
// wps_pkg
// Shared types and constants of the waypoint sequencer: coordinate types,
// the queue entry layout, the reach-unit result and register defaults.
// ----------------------------------------------------------------------------
package wps_pkg;

  // queue depth default and field widths
  localparam int unsigned QueueDepthDef = 16;
  localparam int unsigned CoordW        = 24;
  localparam int unsigned ThrW          = 16;

  // reach threshold after reset: 0.3 m in millimetres
  localparam logic [ThrW-1:0] ThrReset = 16'd300;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef coord_t [2:0] vec3_t;

  // one queued waypoint
  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   land;
  } wp_t;

  // reach unit status back to the sequencer
  typedef struct packed {
    logic done;
    logic reached;
  } reach_res_t;

endpackage

>>> hdl/wps_qmem.sv
// ----------------------------------------------------------------------------
// wps_qmem
// Waypoint queue storage: one write port, one read port, registered read
// data.
// ----------------------------------------------------------------------------
module wps_qmem #(
  parameter int unsigned DEPTH = wps_pkg::QueueDepthDef
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wps_pkg::wp_t             wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output wps_pkg::wp_t             rdata_o
);

  wps_pkg::wp_t mem_q [DEPTH];
  wps_pkg::wp_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/wps_reach.sv
// ----------------------------------------------------------------------------
// wps_reach
// Reach test: squared distance between position and goal against the
// squared threshold, one axis per cycle through a shared multiplier.
// ----------------------------------------------------------------------------
module wps_reach (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  wps_pkg::vec3_t              pos_i,
  input  wps_pkg::vec3_t              goal_i,
  input  logic [wps_pkg::ThrW-1:0]    thr_i,
  output wps_pkg::reach_res_t         res_o
);

  localparam int unsigned MagW  = wps_pkg::CoordW;
  localparam int unsigned ProdW = 2 * MagW;
  localparam int unsigned AccW  = ProdW + 2;
  localparam int unsigned T2W   = 2 * wps_pkg::ThrW;
  localparam logic [2:0]  StepLast = 3'd5;

  logic                  run_q;
  logic [2:0]            step_q;
  logic [MagW-1:0]       absd_q;
  logic [ProdW-1:0]      prod_q;
  logic [AccW-1:0]       acc_q;
  logic [T2W-1:0]        t2_q;
  logic signed [MagW:0]  diff;
  logic [MagW:0]         mag;

  // absolute difference of the current axis
  always_comb begin
    diff = {pos_i[step_q[1:0]][MagW-1], pos_i[step_q[1:0]]}
         - {goal_i[step_q[1:0]][MagW-1], goal_i[step_q[1:0]]};
    mag  = diff[MagW] ? (~diff + 1'b1) : diff;
  end

  // step sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      run_q  <= 1'b1;
      step_q <= '0;
    end else if (run_q) begin
      if (step_q == StepLast) begin
        run_q <= 1'b0;
      end
      step_q <= step_q + 3'd1;
    end
  end

  // subtract, square and accumulate, one stage behind the other
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
    end else if (run_q) begin
      if (step_q < 3'd3) begin
        absd_q <= mag[MagW-1:0];
      end
      if (step_q >= 3'd1 && step_q <= 3'd3) begin
        prod_q <= ProdW'(absd_q) * ProdW'(absd_q);
      end
      if (step_q >= 3'd2 && step_q <= 3'd4) begin
        acc_q <= acc_q + {2'b00, prod_q};
      end
      if (step_q == 3'd0) begin
        t2_q <= T2W'(thr_i) * T2W'(thr_i);
      end
    end
  end

  assign res_o.done    = run_q && (step_q == StepLast);
  assign res_o.reached = acc_q < {{(AccW - T2W){1'b0}}, t2_q};

endmodule

>>> hdl/waypoint_sequencer_unit.sv
// ----------------------------------------------------------------------------
// waypoint_sequencer_unit
// Queues path waypoints in a memory and steers the vehicle through them on
// position ticks, issuing setpoints, landing and completion events.
// ----------------------------------------------------------------------------
// A waypoint item takes the push step, plus a queue read and goal load when it
// commits a path; a standby tick goes straight to the result; a following tick runs
// the reach test, plus the read and goal load when the reached goal is replaced.
// The reach test runs one axis a cycle through one multiplier; the queue memory
// has a single read port with registered read data. One item at a time: busy_o
// stays high through the result strobe. Results cannot be stalled by the receiver.
// Reset clears mode, queue pointers, goal and sets the threshold to 300 mm.
module waypoint_sequencer_unit #(
  parameter int unsigned QUEUE_DEPTH = wps_pkg::QueueDepthDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration
  input  logic                              cfg_we_i,
  input  logic [wps_pkg::ThrW-1:0]          cfg_data_i,
  // item in
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic                              operation_i,
  input  logic signed [wps_pkg::CoordW-1:0] wp_x_i,
  input  logic signed [wps_pkg::CoordW-1:0] wp_y_i,
  input  logic signed [wps_pkg::CoordW-1:0] wp_z_i,
  input  logic                              wp_land_i,
  input  logic                              first_of_path_i,
  input  logic                              last_of_path_i,
  input  logic signed [wps_pkg::CoordW-1:0] pos_x_i,
  input  logic signed [wps_pkg::CoordW-1:0] pos_y_i,
  input  logic signed [wps_pkg::CoordW-1:0] pos_z_i,
  // result out
  output logic                              result_valid_o,
  output logic                              setpoint_valid_o,
  output logic signed [wps_pkg::CoordW-1:0] setpoint_x_o,
  output logic signed [wps_pkg::CoordW-1:0] setpoint_y_o,
  output logic signed [wps_pkg::CoordW-1:0] setpoint_z_o,
  output logic                              land_request_o,
  output logic                              path_complete_o,
  output logic                              path_accepted_o,
  output logic                              queue_overflow_o,
  output logic                              following_o,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]  queued_count_o
);

  localparam int unsigned AddrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW  = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CntW-1:0]  DepthC   = CntW'(QUEUE_DEPTH);
  localparam logic [CntW:0]    DepthW   = (CntW + 1)'(QUEUE_DEPTH);
  localparam logic [AddrW-1:0] LastIdx  = AddrW'(QUEUE_DEPTH - 1);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_PUSH  = 6'b000010,
    ST_READ  = 6'b000100,
    ST_LOAD  = 6'b001000,
    ST_REACH = 6'b010000,
    ST_OUT   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // captured item
  logic                 op_q;
  wps_pkg::wp_t         wp_q;
  logic                 first_q;
  logic                 last_q;
  wps_pkg::vec3_t       pos_q;

  // planner state
  logic [wps_pkg::ThrW-1:0] thr_q;
  logic [AddrW-1:0]     head_q;
  logic [CntW-1:0]      fill_q;
  wps_pkg::wp_t         goal_q;
  logic                 mode_q;

  // result flags
  logic                 sp_q;
  logic                 land_q;
  logic                 done_q;
  logic                 acc_q;
  logic                 ovf_q;

  // queue and reach unit hookup
  logic                 accept;
  logic                 reach_start;
  wps_pkg::reach_res_t  reach_res;
  wps_pkg::vec3_t       goal_vec;
  wps_pkg::wp_t         rdata;
  logic [CntW:0]        tail_sum;
  logic [CntW:0]        tail_wrap;
  logic [AddrW-1:0]     tail;
  logic                 full;
  logic                 push_ok;
  logic                 commit;
  logic                 mem_we;
  logic                 mem_re;
  logic [AddrW-1:0]     head_nxt;

  assign accept      = start_i && (state_q == ST_IDLE);
  assign reach_start = accept && operation_i && mode_q;

  // tail address: head plus fill, wrapped once
  assign tail_sum  = {{(CntW + 1 - AddrW){1'b0}}, head_q} + {1'b0, fill_q};
  assign tail_wrap = (tail_sum >= DepthW) ? (tail_sum - DepthW) : tail_sum;
  assign tail      = tail_wrap[AddrW-1:0];
  assign full      = (fill_q == DepthC);
  assign push_ok   = !first_q && !full;
  assign commit    = last_q && ((fill_q != '0) || push_ok);
  assign head_nxt  = (head_q == LastIdx) ? '0 : head_q + 1'b1;

  assign mem_we = (state_q == ST_PUSH) && push_ok;
  assign mem_re = (state_q == ST_READ);

  assign goal_vec = {goal_q.z, goal_q.y, goal_q.x};

  wps_qmem #(
    .DEPTH (QUEUE_DEPTH)
  ) u_qmem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (tail),
    .wdata_i (wp_q),
    .re_i    (mem_re),
    .raddr_i (head_q),
    .rdata_o (rdata)
  );

  wps_reach u_reach (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (reach_start),
    .pos_i   (pos_q),
    .goal_i  (goal_vec),
    .thr_i   (thr_q),
    .res_o   (reach_res)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          if (!operation_i) begin
            state_d = ST_PUSH;
          end else if (mode_q) begin
            state_d = ST_REACH;
          end else begin
            state_d = ST_OUT;
          end
        end
      end
      ST_PUSH: begin
        state_d = commit ? ST_READ : ST_OUT;
      end
      ST_READ: begin
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        state_d = ST_OUT;
      end
      ST_REACH: begin
        if (reach_res.done) begin
          state_d = ((fill_q != '0) && reach_res.reached) ? ST_READ : ST_OUT;
        end
      end
      ST_OUT: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      thr_q   <= wps_pkg::ThrReset;
      head_q  <= '0;
      fill_q  <= '0;
      goal_q  <= '0;
      mode_q  <= 1'b0;
      sp_q    <= 1'b0;
      land_q  <= 1'b0;
      done_q  <= 1'b0;
      acc_q   <= 1'b0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        thr_q <= cfg_data_i;
      end
      case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            sp_q   <= 1'b0;
            land_q <= 1'b0;
            done_q <= 1'b0;
            acc_q  <= 1'b0;
            ovf_q  <= 1'b0;
          end
        end
        // queue the waypoint unless it opens a path, or flag the drop when full
        ST_PUSH: begin
          if (!first_q) begin
            if (full) begin
              ovf_q <= 1'b1;
            end else begin
              fill_q <= fill_q + 1'b1;
            end
          end
        end
        // head of queue becomes the goal
        ST_LOAD: begin
          goal_q <= rdata;
          head_q <= head_nxt;
          fill_q <= fill_q - 1'b1;
          if (!op_q) begin
            mode_q <= 1'b1;
            acc_q  <= 1'b1;
          end
        end
        // tick decision once the reach test is in
        ST_REACH: begin
          if (reach_res.done) begin
            if (fill_q != '0) begin
              sp_q <= 1'b1;
            end else if (goal_q.land) begin
              land_q <= 1'b1;
              mode_q <= 1'b0;
            end else if (reach_res.reached) begin
              done_q <= 1'b1;
              mode_q <= 1'b0;
            end else begin
              sp_q <= 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // item capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= operation_i;
      wp_q     <= '{x: wp_x_i, y: wp_y_i, z: wp_z_i, land: wp_land_i};
      first_q  <= first_of_path_i;
      last_q   <= last_of_path_i;
      pos_q    <= {pos_z_i, pos_y_i, pos_x_i};
    end
  end

  // result ports
  assign busy_o           = (state_q != ST_IDLE);
  assign result_valid_o   = (state_q == ST_OUT);
  assign setpoint_valid_o = sp_q;
  assign setpoint_x_o     = sp_q ? goal_q.x : '0;
  assign setpoint_y_o     = sp_q ? goal_q.y : '0;
  assign setpoint_z_o     = sp_q ? goal_q.z : '0;
  assign land_request_o   = land_q;
  assign path_complete_o  = done_q;
  assign path_accepted_o  = acc_q;
  assign queue_overflow_o = ovf_q;
  assign following_o      = mode_q;
  assign queued_count_o   = fill_q;

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives waypoint and position-tick items into waypoint_sequencer_unit and
// checks every result against an untimed predictor of queue, goal and mode.
// Directed tests cover path commit, reach, landing, completion and a full
// queue; random paths with near-goal ticks run under several thresholds.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned     DEPTH          = wps_pkg::QueueDepthDef;
  localparam int unsigned     CountW         = $clog2(DEPTH + 1);
  localparam int              WATCHDOG_LIMIT = 2000;
  localparam int              SETTLE_CYCLES  = 12;
  localparam int              PRINT_LIMIT    = 100;
  localparam int unsigned     AWAIT_DEPTH    = 4;
  localparam wps_pkg::coord_t COORD_MAX      = 24'h7FFFFF;
  localparam wps_pkg::coord_t COORD_MIN      = 24'h800000;

  typedef enum logic {
    OP_WAYPOINT = 1'b0,
    OP_TICK     = 1'b1
  } nav_op_e;

  // one input item; pos[0..2] hold x, y, z
  typedef struct packed {
    nav_op_e        op;
    wps_pkg::wp_t   wp;
    logic           first;
    logic           last;
    wps_pkg::vec3_t pos;
  } nav_item_t;

  // one result item
  typedef struct packed {
    logic              sp_valid;
    wps_pkg::coord_t   sp_x;
    wps_pkg::coord_t   sp_y;
    wps_pkg::coord_t   sp_z;
    logic              land_req;
    logic              path_done;
    logic              path_acc;
    logic              overflow;
    logic              following;
    logic [CountW-1:0] queued;
  } step_result_t;

  // dut ports
  logic                     clk_i           = 1'b0;
  logic                     rst_ni          = 1'b0;
  logic                     cfg_we_i        = 1'b0;
  logic [wps_pkg::ThrW-1:0] cfg_data_i      = '0;
  logic                     start_i         = 1'b0;
  logic                     busy_o;
  logic                     operation_i     = 1'b0;
  wps_pkg::coord_t          wp_x_i          = '0;
  wps_pkg::coord_t          wp_y_i          = '0;
  wps_pkg::coord_t          wp_z_i          = '0;
  logic                     wp_land_i       = 1'b0;
  logic                     first_of_path_i = 1'b0;
  logic                     last_of_path_i  = 1'b0;
  wps_pkg::coord_t          pos_x_i         = '0;
  wps_pkg::coord_t          pos_y_i         = '0;
  wps_pkg::coord_t          pos_z_i         = '0;
  logic                     result_valid_o;
  logic                     setpoint_valid_o;
  wps_pkg::coord_t          setpoint_x_o;
  wps_pkg::coord_t          setpoint_y_o;
  wps_pkg::coord_t          setpoint_z_o;
  logic                     land_request_o;
  logic                     path_complete_o;
  logic                     path_accepted_o;
  logic                     queue_overflow_o;
  logic                     following_o;
  logic [CountW-1:0]        queued_count_o;

  // predicted sequencer state
  wps_pkg::wp_t             nav_fifo [DEPTH];
  int unsigned              nav_head      = 0;
  int unsigned              nav_fill      = 0;
  wps_pkg::wp_t             nav_goal      = '0;
  logic                     nav_following = 1'b0;
  logic [wps_pkg::ThrW-1:0] reach_mm      = wps_pkg::ThrReset;

  // predicted results waiting for the block, oldest at the read index
  step_result_t awaited_buf [AWAIT_DEPTH];
  int unsigned  awaited_wr   = 0;
  int unsigned  awaited_rd   = 0;
  step_result_t want_step;
  int           mismatches   = 0;
  int           items_done   = 0;
  int           stall_cycles = 0;
  bit           gaps_on      = 1'b1;

  waypoint_sequencer_unit #(
    .QUEUE_DEPTH(DEPTH)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_data_i      (cfg_data_i),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .operation_i     (operation_i),
    .wp_x_i          (wp_x_i),
    .wp_y_i          (wp_y_i),
    .wp_z_i          (wp_z_i),
    .wp_land_i       (wp_land_i),
    .first_of_path_i (first_of_path_i),
    .last_of_path_i  (last_of_path_i),
    .pos_x_i         (pos_x_i),
    .pos_y_i         (pos_y_i),
    .pos_z_i         (pos_z_i),
    .result_valid_o  (result_valid_o),
    .setpoint_valid_o(setpoint_valid_o),
    .setpoint_x_o    (setpoint_x_o),
    .setpoint_y_o    (setpoint_y_o),
    .setpoint_z_o    (setpoint_z_o),
    .land_request_o  (land_request_o),
    .path_complete_o (path_complete_o),
    .path_accepted_o (path_accepted_o),
    .queue_overflow_o(queue_overflow_o),
    .following_o     (following_o),
    .queued_count_o  (queued_count_o)
  );

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // exact squared-distance reach test against the current goal
  function automatic bit goal_within_reach(wps_pkg::vec3_t pos);
    longint          dx, dy, dz;
    longint unsigned dist2, thr2;
    dx    = longint'(pos[0]) - longint'(nav_goal.x);
    dy    = longint'(pos[1]) - longint'(nav_goal.y);
    dz    = longint'(pos[2]) - longint'(nav_goal.z);
    dist2 = dx * dx + dy * dy + dz * dz;
    thr2  = longint'(reach_mm) * longint'(reach_mm);
    return dist2 < thr2;
  endfunction

  function automatic void pop_goal();
    nav_goal = nav_fifo[nav_head];
    nav_head = (nav_head + 1) % DEPTH;
    nav_fill--;
  endfunction

  // advance the predicted state by one item and return its result
  function automatic step_result_t predict_step(nav_item_t it);
    step_result_t r;
    r = '0;
    if (it.op == OP_WAYPOINT) begin
      if (!it.first) begin
        if (nav_fill >= DEPTH) begin
          r.overflow = 1'b1;
        end else begin
          nav_fifo[(nav_head + nav_fill) % DEPTH] = it.wp;
          nav_fill++;
        end
      end
      if (it.last && nav_fill > 0) begin
        pop_goal();
        nav_following = 1'b1;
        r.path_acc    = 1'b1;
      end
    end else if (nav_following) begin
      if (nav_fill == 0) begin
        if (nav_goal.land) begin
          r.land_req    = 1'b1;
          nav_following = 1'b0;
        end else if (goal_within_reach(it.pos)) begin
          r.path_done   = 1'b1;
          nav_following = 1'b0;
        end else begin
          r.sp_valid = 1'b1;
        end
      end else begin
        if (goal_within_reach(it.pos)) pop_goal();
        r.sp_valid = 1'b1;
      end
      if (r.sp_valid) begin
        r.sp_x = nav_goal.x;
        r.sp_y = nav_goal.y;
        r.sp_z = nav_goal.z;
      end
    end
    r.following = nav_following;
    r.queued    = CountW'(nav_fill);
    return r;
  endfunction

  // item builders; fields the operation ignores carry random values
  function automatic nav_item_t make_waypoint(wps_pkg::coord_t x, wps_pkg::coord_t y,
                                              wps_pkg::coord_t z, logic land,
                                              logic first, logic last);
    nav_item_t it;
    it.op      = OP_WAYPOINT;
    it.wp.x    = x;
    it.wp.y    = y;
    it.wp.z    = z;
    it.wp.land = land;
    it.first   = first;
    it.last    = last;
    it.pos[0]  = wps_pkg::coord_t'($urandom);
    it.pos[1]  = wps_pkg::coord_t'($urandom);
    it.pos[2]  = wps_pkg::coord_t'($urandom);
    return it;
  endfunction

  function automatic nav_item_t make_tick(wps_pkg::coord_t x, wps_pkg::coord_t y,
                                          wps_pkg::coord_t z);
    nav_item_t it;
    it.op      = OP_TICK;
    it.wp.x    = wps_pkg::coord_t'($urandom);
    it.wp.y    = wps_pkg::coord_t'($urandom);
    it.wp.z    = wps_pkg::coord_t'($urandom);
    it.wp.land = 1'($urandom_range(1));
    it.first   = 1'($urandom_range(1));
    it.last    = 1'($urandom_range(1));
    it.pos[0]  = x;
    it.pos[1]  = y;
    it.pos[2]  = z;
    return it;
  endfunction

  function automatic wps_pkg::coord_t rand_coord();
    case ($urandom_range(9))
      0:       return COORD_MAX;
      1:       return COORD_MIN;
      default: return wps_pkg::coord_t'($urandom);
    endcase
  endfunction

  function automatic nav_item_t rand_waypoint(logic first, logic last);
    return make_waypoint(rand_coord(), rand_coord(), rand_coord(),
                         $urandom_range(3) == 0, first, last);
  endfunction

  // signed offset spread around zero
  function automatic longint jitter(int span);
    return longint'(int'($urandom_range(2 * span))) - longint'(span);
  endfunction

  // tick with a position scattered around the predicted goal
  function automatic nav_item_t near_goal_tick();
    int span;
    span = int'(reach_mm) / 2 + 2;
    return make_tick(wps_pkg::coord_t'(longint'(nav_goal.x) + jitter(span)),
                     wps_pkg::coord_t'(longint'(nav_goal.y) + jitter(span)),
                     wps_pkg::coord_t'(longint'(nav_goal.z) + jitter(span)));
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    if (mismatches < PRINT_LIMIT)
      $display("%0t mismatch %s: got %0d want %0d", $time, what, got, want);
    mismatches++;
  endtask

  // send one item: random gaps, then hold start until the block takes it
  task automatic send_item(nav_item_t it);
    while (gaps_on && $urandom_range(99) < 8) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i         <= 1'b1;
    operation_i     <= it.op;
    wp_x_i          <= it.wp.x;
    wp_y_i          <= it.wp.y;
    wp_z_i          <= it.wp.z;
    wp_land_i       <= it.wp.land;
    first_of_path_i <= it.first;
    last_of_path_i  <= it.last;
    pos_x_i         <= it.pos[0];
    pos_y_i         <= it.pos[1];
    pos_z_i         <= it.pos[2];
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    if (it.op == OP_WAYPOINT || nav_following) items_done++;
    awaited_buf[awaited_wr % AWAIT_DEPTH] = predict_step(it);
    awaited_wr++;
  endtask

  // stop sending and let the block drain all outstanding results
  task automatic wait_idle();
    start_i <= 1'b0;
    while (awaited_wr != awaited_rd) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_threshold(logic [wps_pkg::ThrW-1:0] mm);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= mm;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    reach_mm  = mm;
    @(posedge clk_i);
  endtask

  // standby tick, and a one-waypoint path that is discarded, so its commit finds an empty queue
  task automatic test_standby_and_reject();
    send_item(make_tick(COORD_MAX, COORD_MIN, '0));
    send_item(make_waypoint(24'sd5, 24'sd6, 24'sd7, 1'b1, 1'b1, 1'b1));
  endtask

  // four-waypoint path: far, exact, inside and boundary reach, then landing
  task automatic test_path_follow();
    send_item(make_waypoint(24'sd1, 24'sd2, 24'sd3, 1'b0, 1'b1, 1'b0));
    send_item(make_waypoint(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0, 1'b0, 1'b0));
    send_item(make_waypoint(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0, 1'b0, 1'b0));
    send_item(make_waypoint(24'sd100, -24'sd100, 24'sd50, 1'b0, 1'b0, 1'b0));
    send_item(make_waypoint('0, '0, '0, 1'b1, 1'b0, 1'b1));
    send_item(make_tick(COORD_MIN, COORD_MIN, COORD_MIN));
    send_item(make_tick(COORD_MAX, COORD_MAX, COORD_MAX));
    send_item(make_tick(COORD_MIN + 24'sd299, COORD_MIN, COORD_MIN));
    send_item(make_tick(24'sd400, -24'sd100, 24'sd50));
    send_item(make_tick(24'sd273, 24'sd73, 24'sd223));
    // land mark wins without a reach test
    send_item(make_tick(COORD_MAX, COORD_MAX, COORD_MAX));
    send_item(make_tick('0, '0, '0));
  endtask

  // single-waypoint path reached on the second tick
  task automatic test_final_reach();
    send_item(make_waypoint(24'sd1000, 24'sd2000, -24'sd3000, 1'b0, 1'b0, 1'b1));
    send_item(make_tick('0, '0, '0));
    send_item(make_tick(24'sd1000, 24'sd2000, -24'sd2701));
  endtask

  // fill the queue, overflow with a commit, queue while following, re-commit
  task automatic test_queue_full();
    repeat (DEPTH) send_item(rand_waypoint(1'b0, 1'b0));
    send_item(rand_waypoint(1'b0, 1'b1));
    send_item(rand_waypoint(1'b0, 1'b0));
    send_item(rand_waypoint(1'b1, 1'b1));
  endtask

  // zero threshold never reaches; full-scale threshold reaches far away
  task automatic test_threshold_limits();
    wps_pkg::coord_t x;
    wait_idle();
    write_threshold('0);
    send_item(make_tick(nav_goal.x, nav_goal.y, nav_goal.z));
    wait_idle();
    write_threshold('1);
    x = (nav_goal.x < 0) ? nav_goal.x + 24'sd65534 : nav_goal.x - 24'sd65534;
    send_item(make_tick(x, nav_goal.y, nav_goal.z));
  endtask

  // well-formed path with random content, then ticks mostly near the goal
  task automatic run_path();
    int n_wp, n_ticks;
    n_wp = ($urandom_range(9) == 0) ? $urandom_range(10, 18) : $urandom_range(1, 4);
    if ($urandom_range(9) != 0) send_item(rand_waypoint(1'b1, 1'b0));
    repeat (n_wp - 1) send_item(rand_waypoint(1'b0, 1'b0));
    send_item(rand_waypoint(1'b0, 1'b1));
    n_ticks = $urandom_range(2, 24);
    for (int k = 0; k < n_ticks && nav_following; k++) begin
      if ($urandom_range(19) == 0)
        send_item(rand_waypoint(1'b0, 1'($urandom_range(1))));
      else if ($urandom_range(9) < 7)
        send_item(near_goal_tick());
      else
        send_item(make_tick(rand_coord(), rand_coord(), rand_coord()));
    end
  endtask

  // random traffic under one threshold: paths, stray ticks, broken sequences
  task automatic test_random_traffic(logic [wps_pkg::ThrW-1:0] mm, int n_items,
                                     bit gaps);
    int goal_items;
    wait_idle();
    write_threshold(mm);
    gaps_on    = gaps;
    goal_items = items_done + n_items;
    while (items_done < goal_items) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: run_path();
        6, 7:             send_item(make_tick(rand_coord(), rand_coord(), rand_coord()));
        default:          send_item(rand_waypoint(1'($urandom_range(1)),
                                                  1'($urandom_range(1))));
      endcase
    end
    gaps_on = 1'b1;
  endtask

  // compare each result against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (awaited_wr == awaited_rd) begin
        report_mismatch("result with nothing pending", 1, 0);
      end else begin
        want_step = awaited_buf[awaited_rd % AWAIT_DEPTH];
        awaited_rd++;
        if (setpoint_valid_o !== want_step.sp_valid)
          report_mismatch("setpoint_valid", setpoint_valid_o, want_step.sp_valid);
        if (setpoint_x_o !== want_step.sp_x)
          report_mismatch("setpoint_x", setpoint_x_o, want_step.sp_x);
        if (setpoint_y_o !== want_step.sp_y)
          report_mismatch("setpoint_y", setpoint_y_o, want_step.sp_y);
        if (setpoint_z_o !== want_step.sp_z)
          report_mismatch("setpoint_z", setpoint_z_o, want_step.sp_z);
        if (land_request_o !== want_step.land_req)
          report_mismatch("land_request", land_request_o, want_step.land_req);
        if (path_complete_o !== want_step.path_done)
          report_mismatch("path_complete", path_complete_o, want_step.path_done);
        if (path_accepted_o !== want_step.path_acc)
          report_mismatch("path_accepted", path_accepted_o, want_step.path_acc);
        if (queue_overflow_o !== want_step.overflow)
          report_mismatch("queue_overflow", queue_overflow_o, want_step.overflow);
        if (following_o !== want_step.following)
          report_mismatch("following", following_o, want_step.following);
        if (queued_count_o !== want_step.queued)
          report_mismatch("queued_count", queued_count_o, want_step.queued);
      end
    end
  end

  // watchdog on cycles with neither an accepted item nor a result
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || result_valid_o)
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // test sequence
  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_standby_and_reject();
    test_path_follow();
    test_final_reach();
    test_queue_full();
    test_threshold_limits();
    test_random_traffic(wps_pkg::ThrReset, 150, 1'b1);
    test_random_traffic(wps_pkg::ThrW'($urandom), 150, 1'b1);
    test_random_traffic('0, 100, 1'b1);
    test_random_traffic('1, 150, 1'b1);
    test_random_traffic(wps_pkg::ThrW'($urandom_range(50, 3000)), 200, 1'b0);
    wait_idle();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/wps_pkg.sv
hdl/wps_qmem.sv
hdl/wps_reach.sv
hdl/waypoint_sequencer_unit.sv
tb/testbench.sv
